// ===== hw/rtl/rpj_pkg.sv =====
package rpj_pkg;

    localparam int MAX_WIDTH     = 2048;
    localparam int MAX_HEIGHT    = 2048;
    localparam int BORDER_MARGIN = 20;

    localparam int QUOT_BITS = 31;
    localparam int NUM_BITS  = 63;
    localparam int DEN_BITS  = 40;

    localparam logic [30:0] Z_MAX   = 31'h7FFF_FFFF;
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_MAX = 32'h8000_0000;

    localparam logic [2:0] REG_DISPARITY_GAIN = 3'd0;
    localparam logic [2:0] REG_MIN_DISPARITY  = 3'd1;
    localparam logic [2:0] REG_FOCAL_BASELINE = 3'd2;
    localparam logic [2:0] REG_CENTER_X       = 3'd3;
    localparam logic [2:0] REG_CENTER_Y       = 3'd4;
    localparam logic [2:0] REG_FOCAL_X        = 3'd5;
    localparam logic [2:0] REG_FOCAL_Y        = 3'd6;
    localparam logic [2:0] REG_IMAGE_WIDTH    = 3'd7;

    typedef struct packed {
        logic [10:0] row;
        logic [10:0] column;
        logic [15:0] raw_disparity;
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
    } in_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic [30:0]        point_z;
        logic [7:0]         red_out;
        logic [7:0]         green_out;
        logic [7:0]         blue_out;
    } out_t;

    typedef struct packed {
        logic [31:0] mag_x;
        logic        neg_x;
        logic [31:0] mag_y;
        logic        neg_y;
        logic [30:0] z;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } tag_t;

endpackage

// ===== hw/rtl/rpj_qdiv.sv =====
module rpj_qdiv (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [rpj_pkg::NUM_BITS-1:0]      in_num,
    input  logic [rpj_pkg::DEN_BITS-1:0]      in_den,
    input  rpj_pkg::tag_t                     in_tag,
    output logic                              out_valid,
    output logic [rpj_pkg::QUOT_BITS-1:0]     out_quot,
    output logic                              out_ovf,
    output rpj_pkg::tag_t                     out_tag
);
    import rpj_pkg::*;

    logic                 v_reg    [0:QUOT_BITS];
    logic [DEN_BITS-1:0]  rem_reg  [0:QUOT_BITS];
    logic [DEN_BITS-1:0]  den_reg  [0:QUOT_BITS];
    logic [QUOT_BITS-1:0] lo_reg   [0:QUOT_BITS];
    logic [QUOT_BITS-1:0] quot_reg [0:QUOT_BITS];
    logic                 ovf_reg  [0:QUOT_BITS];
    tag_t                 tag_reg  [0:QUOT_BITS];

    logic ovf_next;

    // quotient overflows 31 bits when num >= den * 2^31
    assign ovf_next = {8'b0, in_num} >= {in_den, 31'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= {8'b0, in_num[NUM_BITS-1:QUOT_BITS]};
            den_reg[0]  <= in_den;
            lo_reg[0]   <= in_num[QUOT_BITS-1:0];
            quot_reg[0] <= '0;
            ovf_reg[0]  <= ovf_next;
            tag_reg[0]  <= in_tag;
        end
    end

    genvar k;
    generate
        for (k = 1; k <= QUOT_BITS; k++) begin : g_step
            logic [DEN_BITS:0] shifted;
            logic [DEN_BITS:0] diff;
            logic              fits;

            assign shifted = {rem_reg[k-1], lo_reg[k-1][QUOT_BITS-1]};
            assign diff    = shifted - {1'b0, den_reg[k-1]};
            assign fits    = shifted >= {1'b0, den_reg[k-1]};

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[k] <= 1'b0;
                end else if (en) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k]  <= fits ? diff[DEN_BITS-1:0] : shifted[DEN_BITS-1:0];
                    den_reg[k]  <= den_reg[k-1];
                    lo_reg[k]   <= {lo_reg[k-1][QUOT_BITS-2:0], 1'b0};
                    quot_reg[k] <= {quot_reg[k-1][QUOT_BITS-2:0], fits};
                    ovf_reg[k]  <= ovf_reg[k-1];
                    tag_reg[k]  <= tag_reg[k-1];
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[QUOT_BITS];
    assign out_quot  = quot_reg[QUOT_BITS];
    assign out_ovf   = ovf_reg[QUOT_BITS];
    assign out_tag   = tag_reg[QUOT_BITS];

endmodule

// ===== hw/rtl/disparity_to_point_reprojection.sv =====
// path: stage a, depth divider, stage c, lateral dividers, output reg to m_valid
// throughput: one pixel per unstalled cycle, set by the pipelined 31-step dividers
// a dropped pixel leaves a bubble and gives no result
// the whole pipeline stalls together while a result waits on m_ready
// reset (aresetn low, synchronous) clears all valid bits and loads register defaults
module disparity_to_point_reprojection (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  rpj_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output rpj_pkg::out_t  m_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [7:0]     cfg_index,
    input  logic [31:0]    cfg_data
);
    import rpj_pkg::*;

    logic [23:0] gain_reg;
    logic [31:0] min_disp_reg;
    logic [31:0] fb_reg;
    logic [31:0] cx_reg;
    logic [31:0] cy_reg;
    logic [31:0] fx_reg;
    logic [31:0] fy_reg;
    logic [11:0] width_reg;

    logic en;
    assign en        = !m_valid || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg     <= 24'd65536;
            min_disp_reg <= 32'd0;
            fb_reg       <= 32'd65536;
            cx_reg       <= 32'd0;
            cy_reg       <= 32'd0;
            fx_reg       <= 32'd65536;
            fy_reg       <= 32'd65536;
            width_reg    <= 12'd640;
        end else if (cfg_valid && cfg_index[7:3] == 5'd0) begin
            unique case (cfg_index[2:0])
                REG_DISPARITY_GAIN: gain_reg     <= cfg_data[23:0];
                REG_MIN_DISPARITY:  min_disp_reg <= cfg_data;
                REG_FOCAL_BASELINE: fb_reg       <= cfg_data;
                REG_CENTER_X:       cx_reg       <= cfg_data;
                REG_CENTER_Y:       cy_reg       <= cfg_data;
                REG_FOCAL_X:        fx_reg       <= cfg_data;
                REG_FOCAL_Y:        fy_reg       <= cfg_data;
                REG_IMAGE_WIDTH:    width_reg    <= cfg_data[11:0];
                default:            ;
            endcase
        end
    end

    // stage a: scale, border test, offsets from the principal point
    logic        a_v_reg;
    logic [39:0] a_d_reg;
    logic        a_ok_reg;
    tag_t        a_tag_reg;

    logic [11:0] width_eff;
    logic        ok_next;
    logic [26:0] px_pos;
    logic [26:0] py_pos;
    tag_t        a_tag_next;

    assign width_eff = (width_reg > 12'(MAX_WIDTH)) ? 12'(MAX_WIDTH) : width_reg;
    assign ok_next   = (s_data.column >= 11'(BORDER_MARGIN))
                     && (({1'b0, s_data.column} + 12'(BORDER_MARGIN)) < width_eff);
    assign px_pos    = {s_data.column, 16'b0};
    assign py_pos    = {s_data.row, 16'b0};

    always_comb begin
        a_tag_next       = '0;
        a_tag_next.neg_x = {5'b0, px_pos} < cx_reg;
        a_tag_next.mag_x = a_tag_next.neg_x ? (cx_reg - {5'b0, px_pos})
                                            : ({5'b0, px_pos} - cx_reg);
        a_tag_next.neg_y = {5'b0, py_pos} < cy_reg;
        a_tag_next.mag_y = a_tag_next.neg_y ? (cy_reg - {5'b0, py_pos})
                                            : ({5'b0, py_pos} - cy_reg);
        a_tag_next.red   = s_data.red_in;
        a_tag_next.green = s_data.green_in;
        a_tag_next.blue  = s_data.blue_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
        end else if (en) begin
            a_v_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_d_reg   <= 40'(s_data.raw_disparity) * 40'(gain_reg);
            a_ok_reg  <= ok_next;
            a_tag_reg <= a_tag_next;
        end
    end

    // depth division
    logic                 zin_valid;
    logic                 zq_valid;
    logic [QUOT_BITS-1:0] zq_quot;
    logic                 zq_ovf;
    tag_t                 zq_tag;

    assign zin_valid = a_v_reg && a_ok_reg && (a_d_reg != 40'd0)
                     && (a_d_reg >= {8'b0, min_disp_reg});

    rpj_qdiv u_zdiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (zin_valid),
        .in_num    ({15'b0, fb_reg, 16'b0}),
        .in_den    (a_d_reg),
        .in_tag    (a_tag_reg),
        .out_valid (zq_valid),
        .out_quot  (zq_quot),
        .out_ovf   (zq_ovf),
        .out_tag   (zq_tag)
    );

    // stage c: offset times depth
    logic        c_v_reg;
    logic [62:0] c_prod_x_reg;
    logic [62:0] c_prod_y_reg;
    tag_t        c_tag_reg;
    logic [30:0] z_sat;
    tag_t        c_tag_next;

    assign z_sat = zq_ovf ? Z_MAX : zq_quot;

    always_comb begin
        c_tag_next   = zq_tag;
        c_tag_next.z = z_sat;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_v_reg <= 1'b0;
        end else if (en) begin
            c_v_reg <= zq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_prod_x_reg <= 63'(zq_tag.mag_x) * 63'(z_sat);
            c_prod_y_reg <= 63'(zq_tag.mag_y) * 63'(z_sat);
            c_tag_reg    <= c_tag_next;
        end
    end

    // lateral divisions
    logic [39:0]          fx_eff;
    logic [39:0]          fy_eff;
    logic                 xq_valid;
    logic [QUOT_BITS-1:0] xq_quot;
    logic                 xq_ovf;
    tag_t                 xq_tag;
    logic                 yq_valid;
    logic [QUOT_BITS-1:0] yq_quot;
    logic                 yq_ovf;
    tag_t                 yq_tag;

    assign fx_eff = (fx_reg == 32'd0) ? 40'd1 : {8'b0, fx_reg};
    assign fy_eff = (fy_reg == 32'd0) ? 40'd1 : {8'b0, fy_reg};

    rpj_qdiv u_xdiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (c_v_reg),
        .in_num    (c_prod_x_reg),
        .in_den    (fx_eff),
        .in_tag    (c_tag_reg),
        .out_valid (xq_valid),
        .out_quot  (xq_quot),
        .out_ovf   (xq_ovf),
        .out_tag   (xq_tag)
    );

    rpj_qdiv u_ydiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (c_v_reg),
        .in_num    (c_prod_y_reg),
        .in_den    (fy_eff),
        .in_tag    (c_tag_reg),
        .out_valid (yq_valid),
        .out_quot  (yq_quot),
        .out_ovf   (yq_ovf),
        .out_tag   (yq_tag)
    );

    // output register
    logic m_valid_reg;
    out_t m_data_reg;
    out_t m_data_next;

    always_comb begin
        m_data_next = '0;
        if (xq_ovf) begin
            m_data_next.point_x = xq_tag.neg_x ? NEG_MAX : POS_MAX;
        end else begin
            m_data_next.point_x = xq_tag.neg_x ? (32'd0 - {1'b0, xq_quot}) : {1'b0, xq_quot};
        end
        if (yq_ovf) begin
            m_data_next.point_y = yq_tag.neg_y ? NEG_MAX : POS_MAX;
        end else begin
            m_data_next.point_y = yq_tag.neg_y ? (32'd0 - {1'b0, yq_quot}) : {1'b0, yq_quot};
        end
        m_data_next.point_z   = xq_tag.z;
        m_data_next.red_out   = yq_tag.red;
        m_data_next.green_out = yq_tag.green;
        m_data_next.blue_out  = yq_tag.blue;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= xq_valid && yq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== hw/rtl/rpj_checker.sv =====
module rpj_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input rpj_pkg::out_t m_data,
    input logic          cfg_valid,
    input logic          cfg_ready
);

    // a held result keeps its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // no result right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // the pipeline takes a request whenever the output is free
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input stalled with free output");

    // the input stalls only behind a held result
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && !s_ready) |-> (m_valid && !m_ready))
        else $error("input stalled without cause");

    // register writes are never refused
    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("register write refused");

endmodule

bind disparity_to_point_reprojection rpj_checker u_rpj_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
